FILE: rtl/core/polyline_equal_length_resampler_unit_macros.svh
// Assertion macros for the polyline resampler checker.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef POLYLINE_EQUAL_LENGTH_RESAMPLER_UNIT_MACROS_SVH
`define POLYLINE_EQUAL_LENGTH_RESAMPLER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PELR_ASSERT_IMP(lbl, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) \
    else $error("pelr check failed");

// Next-cycle implication, disabled during reset.
`define PELR_ASSERT_NXT(lbl, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (con)) \
    else $error("pelr check failed");

`endif

FILE: rtl/core/pelr_pkg.sv
// Shared types and constants of the polyline resampler.
// No dependencies.
`default_nettype none
package pelr_pkg;

  localparam int VERTEX_DEPTH = 64;
  localparam int VIDX_W       = $clog2(VERTEX_DEPTH);
  localparam int CNT_W        = $clog2(VERTEX_DEPTH + 1);
  localparam int COORD_W      = 32;
  localparam int VTX_W        = 3 * COORD_W;
  localparam int ROOT_W       = 33;
  localparam int TOT_W        = 40;
  localparam int RAD_W        = 66;
  localparam int DVD_W        = 66;
  localparam int DVS_W        = 34;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DROP  = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

  typedef struct packed {
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic               last_vertex;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [5:0]         vertex_index;
    logic               last_out;
    logic [1:0]         status;
  } out_item_t;

endpackage
`default_nettype wire

FILE: rtl/core/pelr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pelr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/pelr_sqrt.sv
// Iterative floor square root, two radicand bits per cycle.
// Depends on pelr_pkg.
`default_nettype none
module pelr_sqrt import pelr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [RAD_W-1:0]  radicand,
  output logic                   done,
  output logic [ROOT_W-1:0]      root
);
  localparam int STEPS = RAD_W / 2;
  localparam int REM_W = ROOT_W + 5;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [REM_W-1:0]  rem_sh, trial;

  always_comb begin
    rem_sh   = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial    = REM_W'({root_r, 2'b01});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;
endmodule
`default_nettype wire

FILE: rtl/core/pelr_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on pelr_pkg.
`default_nettype none
module pelr_div import pelr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [6:0]       cnt_r, cnt_nxt;
  logic [DVD_W-1:0] dq_r, dq_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W:0]   rem_sh;
  logic             ge;

  always_comb begin
    rem_sh   = {rem_r, dq_r[DVD_W-1]};
    ge       = rem_sh >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dq_nxt   = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? DVS_W'(rem_sh - {1'b0, dvs_r}) : DVS_W'(rem_sh);
      dq_nxt  = {dq_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dq_r  <= dq_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = dq_r;
endmodule
`default_nettype wire

FILE: rtl/core/polyline_equal_length_resampler_unit.sv
// Flow: vertices load while idle; each edge is measured with the square root, the
// spacing comes from the divider, each moved vertex takes a divide per axis, then all are emitted.
// One polyline at a time; the iterative square root and divider and the single
// read port of each RAM set the pace.
// Reset: synchronous active-low rst_n clears control state; closed_curve = 1.
// Depends on pelr_pkg, pelr_ram, pelr_sqrt, pelr_div.
`default_nettype none
module polyline_equal_length_resampler_unit import pelr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic      cfg_data
);
  // Sequencer states.
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_L_RDA  = 5'd1;
  localparam logic [4:0] S_L_RDB  = 5'd2;
  localparam logic [4:0] S_L_CAPB = 5'd3;
  localparam logic [4:0] S_L_MUL  = 5'd4;
  localparam logic [4:0] S_L_ACC  = 5'd5;
  localparam logic [4:0] S_L_SQST = 5'd6;
  localparam logic [4:0] S_L_SQRT = 5'd7;
  localparam logic [4:0] S_G_ST   = 5'd8;
  localparam logic [4:0] S_G_WAIT = 5'd9;
  localparam logic [4:0] S_W_RDL  = 5'd10;
  localparam logic [4:0] S_W_RDB  = 5'd11;
  localparam logic [4:0] S_W_CAPB = 5'd12;
  localparam logic [4:0] S_W_CHK  = 5'd13;
  localparam logic [4:0] S_W_M0   = 5'd14;
  localparam logic [4:0] S_W_M1   = 5'd15;
  localparam logic [4:0] S_W_DST  = 5'd16;
  localparam logic [4:0] S_W_DIV  = 5'd17;
  localparam logic [4:0] S_W_WR   = 5'd18;
  localparam logic [4:0] S_E_RD   = 5'd19;
  localparam logic [4:0] S_E_WAIT = 5'd20;

  logic [4:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               ovf_r, ovf_nxt;
  logic               closed_r, closed_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [CNT_W-1:0]   edges_r, edges_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [CNT_W-1:0]   j_r, j_nxt;
  logic [1:0]         ax_r, ax_nxt;
  logic [TOT_W-1:0]   total_r, total_nxt;
  logic [TOT_W-1:0]   goal_r, goal_nxt;
  logic [TOT_W-1:0]   left_r, left_nxt;
  logic [TOT_W-1:0]   tg_r, tg_nxt;
  logic [TOT_W-1:0]   used_r, used_nxt;
  logic [ROOT_W-1:0]  len_r, len_nxt;
  logic [VTX_W-1:0]   va_r, va_nxt;
  logic [VTX_W-1:0]   vb_r, vb_nxt;
  logic [RAD_W-1:0]   acc_r, acc_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic [63:0]        plo_r, plo_nxt;
  logic [COORD_W-1:0] pos_r [3];
  logic [COORD_W-1:0] pos_nxt [3];
  out_item_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  // RAM ports.
  logic               vt_we, vt_re, rs_we, rs_re, ln_we, ln_re;
  logic [VIDX_W-1:0]  vt_waddr, vt_raddr, rs_waddr, rs_raddr, ln_waddr, ln_raddr;
  logic [VTX_W-1:0]   vt_wdata, vt_rdata, rs_wdata, rs_rdata;
  logic [ROOT_W-1:0]  ln_wdata, ln_rdata;

  // Arithmetic units.
  logic               sq_start, sq_done;
  logic [ROOT_W-1:0]  sq_root;
  logic               dv_start, dv_done;
  logic [DVD_W-1:0]   dv_dividend, dv_quotient;
  logic [DVS_W-1:0]   dv_divisor;

  // Datapath helpers.
  logic               in_acc;
  logic [CNT_W-1:0]   cnt_inc, nx_k, nx_i;
  logic               ovf_inc;
  logic [COORD_W-1:0] a_ax, b_ax;
  logic [COORD_W:0]   s_ax, s_mag;
  logic               s_neg;
  logic [COORD_W-1:0] m_ax;
  logic [COORD_W-1:0] mul_b;
  logic [63:0]        mul_p;
  logic [TOT_W-1:0]   t_w;
  logic [COORD_W:0]   v_w;

  pelr_ram #(.WIDTH(VTX_W), .DEPTH(VERTEX_DEPTH)) u_vert_ram (
    .clk(clk), .we(vt_we), .waddr(vt_waddr), .wdata(vt_wdata),
    .re(vt_re), .raddr(vt_raddr), .rdata(vt_rdata)
  );

  pelr_ram #(.WIDTH(VTX_W), .DEPTH(VERTEX_DEPTH)) u_res_ram (
    .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
    .re(rs_re), .raddr(rs_raddr), .rdata(rs_rdata)
  );

  pelr_ram #(.WIDTH(ROOT_W), .DEPTH(VERTEX_DEPTH)) u_len_ram (
    .clk(clk), .we(ln_we), .waddr(ln_waddr), .wdata(ln_wdata),
    .re(ln_re), .raddr(ln_raddr), .rdata(ln_rdata)
  );

  pelr_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(acc_r),
    .done(sq_done), .root(sq_root)
  );

  pelr_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_dividend),
    .divisor(dv_divisor), .done(dv_done), .quotient(dv_quotient)
  );

  // Take requests only while idle; configuration is always taken.
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Successor of an edge start: wrap to vertex zero after the last vertex.
  assign nx_k = (k_r + 1'b1 == cnt_r) ? '0 : k_r + 1'b1;
  assign nx_i = (i_r + 1'b1 == cnt_r) ? '0 : i_r + 1'b1;

  // Per-axis difference of the current edge; x sits in the top word.
  always_comb begin
    case (ax_r)
      2'd0:    begin a_ax = va_r[3*COORD_W-1 -: COORD_W]; b_ax = vb_r[3*COORD_W-1 -: COORD_W]; end
      2'd1:    begin a_ax = va_r[2*COORD_W-1 -: COORD_W]; b_ax = vb_r[2*COORD_W-1 -: COORD_W]; end
      default: begin a_ax = va_r[COORD_W-1:0];            b_ax = vb_r[COORD_W-1:0];            end
    endcase
  end

  assign s_ax  = {b_ax[COORD_W-1], b_ax} - {a_ax[COORD_W-1], a_ax};
  assign s_neg = s_ax[COORD_W];
  assign s_mag = s_neg ? -s_ax : s_ax;
  assign m_ax  = s_mag[COORD_W-1:0];

  // Arc-length offset of the point being placed on the current edge.
  assign t_w = tg_r + used_r;

  // One shared 32x32 multiplier: squares while measuring, split |s|*t while walking.
  always_comb begin
    case (state_r)
      S_W_M0:  mul_b = 32'(t_w[16:0]);
      S_W_M1:  mul_b = 32'(t_w[33:17]);
      default: mul_b = m_ax;
    endcase
  end
  assign mul_p = m_ax * mul_b;

  // New coordinate: step from a toward b by the quotient.
  assign v_w = s_neg ? ({a_ax[COORD_W-1], a_ax} - {1'b0, dv_quotient[COORD_W-1:0]})
                     : ({a_ax[COORD_W-1], a_ax} + {1'b0, dv_quotient[COORD_W-1:0]});

  assign ovf_inc = (cnt_r == CNT_W'(VERTEX_DEPTH));
  assign cnt_inc = ovf_inc ? cnt_r : cnt_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    closed_nxt    = closed_r;
    status_nxt    = status_r;
    edges_nxt     = edges_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    ax_nxt        = ax_r;
    total_nxt     = total_r;
    goal_nxt      = goal_r;
    left_nxt      = left_r;
    tg_nxt        = tg_r;
    used_nxt      = used_r;
    len_nxt       = len_r;
    va_nxt        = va_r;
    vb_nxt        = vb_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    plo_nxt       = plo_r;
    pos_nxt       = pos_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    vt_we         = 1'b0;
    vt_waddr      = cnt_r[VIDX_W-1:0];
    vt_wdata      = {in_data.coord_x, in_data.coord_y, in_data.coord_z};
    vt_re         = 1'b0;
    vt_raddr      = k_r[VIDX_W-1:0];
    rs_we         = 1'b0;
    rs_waddr      = cnt_r[VIDX_W-1:0];
    rs_wdata      = {in_data.coord_x, in_data.coord_y, in_data.coord_z};
    rs_re         = 1'b0;
    rs_raddr      = k_r[VIDX_W-1:0];
    ln_we         = 1'b0;
    ln_waddr      = k_r[VIDX_W-1:0];
    ln_wdata      = sq_root;
    ln_re         = 1'b0;
    ln_raddr      = i_r[VIDX_W-1:0];
    sq_start      = 1'b0;
    dv_start      = 1'b0;
    dv_dividend   = RAD_W'(total_r);
    dv_divisor    = DVS_W'(edges_r);

    if (cfg_valid) begin
      closed_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // Store the vertex twice: original copy for the walk, working copy for output.
          vt_we   = !ovf_inc;
          rs_we   = !ovf_inc;
          cnt_nxt = cnt_inc;
          ovf_nxt = ovf_r || ovf_inc;
          if (in_data.last_vertex) begin
            status_nxt = (ovf_r || ovf_inc) ? ST_DROP :
                         (cnt_inc < CNT_W'(3)) ? ST_SHORT : ST_OK;
            edges_nxt  = closed_r ? cnt_inc : cnt_inc - 1'b1;
            k_nxt      = '0;
            total_nxt  = '0;
            state_nxt  = (cnt_inc < CNT_W'(3)) ? S_E_RD : S_L_RDA;
          end
        end
      end
      // Measure edge k.
      S_L_RDA: begin
        vt_re     = 1'b1;
        state_nxt = S_L_RDB;
      end
      S_L_RDB: begin
        va_nxt    = vt_rdata;
        vt_re     = 1'b1;
        vt_raddr  = nx_k[VIDX_W-1:0];
        state_nxt = S_L_CAPB;
      end
      S_L_CAPB: begin
        vb_nxt    = vt_rdata;
        ax_nxt    = '0;
        acc_nxt   = '0;
        state_nxt = S_L_MUL;
      end
      S_L_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_L_ACC;
      end
      S_L_ACC: begin
        acc_nxt = acc_r + RAD_W'(prod_r);
        if (ax_r == 2'd2) begin
          state_nxt = S_L_SQST;
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = S_L_MUL;
        end
      end
      S_L_SQST: begin
        sq_start  = 1'b1;
        state_nxt = S_L_SQRT;
      end
      S_L_SQRT: begin
        if (sq_done) begin
          ln_we     = 1'b1;
          total_nxt = total_r + TOT_W'(sq_root);
          k_nxt     = k_r + 1'b1;
          state_nxt = (k_r + 1'b1 == edges_r) ? S_G_ST : S_L_RDA;
        end
      end
      // Spacing = total length / edge count.
      S_G_ST: begin
        dv_start  = 1'b1;
        state_nxt = S_G_WAIT;
      end
      S_G_WAIT: begin
        if (dv_done) begin
          goal_nxt = dv_quotient[TOT_W-1:0];
          k_nxt    = '0;
          i_nxt    = '0;
          j_nxt    = CNT_W'(1);
          used_nxt = '0;
          tg_nxt   = dv_quotient[TOT_W-1:0];
          state_nxt = (dv_quotient[TOT_W-1:0] == '0) ? S_E_RD : S_W_RDL;
        end
      end
      // Fetch edge i: its length and both end vertices.
      S_W_RDL: begin
        ln_re     = 1'b1;
        vt_re     = 1'b1;
        vt_raddr  = i_r[VIDX_W-1:0];
        state_nxt = S_W_RDB;
      end
      S_W_RDB: begin
        len_nxt   = ln_rdata;
        left_nxt  = TOT_W'(ln_rdata);
        va_nxt    = vt_rdata;
        vt_re     = 1'b1;
        vt_raddr  = nx_i[VIDX_W-1:0];
        state_nxt = S_W_CAPB;
      end
      S_W_CAPB: begin
        vb_nxt    = vt_rdata;
        state_nxt = S_W_CHK;
      end
      S_W_CHK: begin
        if (left_r > tg_r) begin
          // Next point lies on this edge, unless the walk has run past the moveable range.
          if (j_r >= edges_r) begin
            k_nxt     = '0;
            state_nxt = S_E_RD;
          end else begin
            ax_nxt    = '0;
            state_nxt = S_W_M0;
          end
        end else begin
          // Advance to the next edge, carrying the unspent spacing.
          tg_nxt   = tg_r - left_r;
          used_nxt = '0;
          i_nxt    = i_r + 1'b1;
          k_nxt    = '0;
          state_nxt = (i_r + 1'b1 < edges_r) ? S_W_RDL : S_E_RD;
        end
      end
      S_W_M0: begin
        prod_nxt  = mul_p;
        state_nxt = S_W_M1;
      end
      S_W_M1: begin
        plo_nxt   = prod_r;
        prod_nxt  = mul_p;
        state_nxt = S_W_DST;
      end
      S_W_DST: begin
        dv_start    = 1'b1;
        dv_dividend = RAD_W'(plo_r) + (RAD_W'(prod_r) << 17);
        dv_divisor  = DVS_W'(len_r);
        state_nxt   = S_W_DIV;
      end
      S_W_DIV: begin
        dv_divisor = DVS_W'(len_r);
        if (dv_done) begin
          pos_nxt[ax_r] = v_w[COORD_W-1:0];
          if (ax_r == 2'd2) begin
            state_nxt = S_W_WR;
          end else begin
            ax_nxt    = ax_r + 2'd1;
            state_nxt = S_W_M0;
          end
        end
      end
      S_W_WR: begin
        rs_we     = 1'b1;
        rs_waddr  = j_r[VIDX_W-1:0];
        rs_wdata  = {pos_r[0], pos_r[1], pos_r[2]};
        left_nxt  = left_r - tg_r;
        used_nxt  = used_r + tg_r;
        tg_nxt    = goal_r;
        j_nxt     = j_r + 1'b1;
        state_nxt = S_W_CHK;
      end
      // Emit all vertices in order.
      S_E_RD: begin
        rs_re     = 1'b1;
        state_nxt = S_E_WAIT;
      end
      S_E_WAIT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.out_x        = rs_rdata[3*COORD_W-1 -: COORD_W];
          out_nxt.out_y        = rs_rdata[2*COORD_W-1 -: COORD_W];
          out_nxt.out_z        = rs_rdata[COORD_W-1:0];
          out_nxt.vertex_index = 6'(k_r);
          out_nxt.last_out     = (k_r + 1'b1 == cnt_r);
          out_nxt.status       = status_r;
          out_valid_nxt        = 1'b1;
          if (k_r + 1'b1 == cnt_r) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_E_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      closed_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      closed_r    <= closed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r <= status_nxt;
    edges_r  <= edges_nxt;
    k_r      <= k_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    ax_r     <= ax_nxt;
    total_r  <= total_nxt;
    goal_r   <= goal_nxt;
    left_r   <= left_nxt;
    tg_r     <= tg_nxt;
    used_r   <= used_nxt;
    len_r    <= len_nxt;
    va_r     <= va_nxt;
    vb_r     <= vb_nxt;
    acc_r    <= acc_nxt;
    prod_r   <= prod_nxt;
    plo_r    <= plo_nxt;
    pos_r    <= pos_nxt;
    out_r    <= out_nxt;
  end
endmodule
`default_nettype wire

FILE: rtl/core/pelr_chk.sv
// Port-level checker for the polyline resampler, bound to the top level.
// Depends on pelr_pkg and the assertion macro header.
`default_nettype none
`include "polyline_equal_length_resampler_unit_macros.svh"
module pelr_chk import pelr_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);
  `PELR_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `PELR_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_data))
  `PELR_ASSERT_IMP(a_busy_emit, out_valid && !out_data.last_out, in_stall)
  `PELR_ASSERT_IMP(a_short_idx, out_valid && out_data.status == ST_SHORT,
                   out_data.vertex_index < 6'd3)
endmodule

bind polyline_equal_length_resampler_unit pelr_chk u_pelr_chk (.*);
`default_nettype wire

FILE: tb/tb_polyline_equal_length_resampler_unit.sv
// Self-checking testbench for polyline_equal_length_resampler_unit.
// Holds its own arc-length resampling predictor; depends on pelr_pkg and the RTL.
`default_nettype none
module tb_polyline_equal_length_resampler_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import pelr_pkg::*;

  localparam int STALL_LIMIT = 200000;  // cycles with no request moving on any channel
  localparam int HOLD_CYCLES = 2500;    // long receiver hold-off for the pressure test

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b1;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  polyline_equal_length_resampler_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Predictor state: a private copy of the vertex store and the register.
  logic [31:0] pv_x [VERTEX_DEPTH];
  logic [31:0] pv_y [VERTEX_DEPTH];
  logic [31:0] pv_z [VERTEX_DEPTH];
  longint unsigned edge_len [VERTEX_DEPTH];
  int          pv_count = 0;
  bit          pv_dropped = 0;
  bit          closed_reg = 1;

  out_item_t   resampled_q[$];   // vertices the block still owes us
  int          fail_count = 0;
  int          sent_count = 0;
  bit          no_idle = 0;      // run without gaps on either side
  bit          hold_req = 0;     // ask the receiver for one long hold-off

  // Floor square root of a value below 2^66, one result bit per step.
  function automatic longint unsigned floor_root(input logic [65:0] v);
    logic [69:0] rem;
    logic [69:0] trial;
    logic [33:0] root;
    rem = '0;
    root = '0;
    for (int p = 32; p >= 0; p--) begin
      rem = (rem << 2) | v[2*p +: 2];
      trial = {root, 2'b01};
      if (rem >= trial) begin
        rem = rem - trial;
        root = {root[32:0], 1'b1};
      end else begin
        root = {root[32:0], 1'b0};
      end
    end
    return longint'(root);
  endfunction

  // Point at offset t along a -> b of length len, one axis.
  function automatic logic [31:0] lerp_axis(input logic [31:0] a, input logic [31:0] b,
                                            input longint unsigned t,
                                            input longint unsigned len);
    longint sa;
    longint sd;
    logic [127:0] prod;
    longint off;
    longint v;
    sa = longint'($signed(a));
    sd = longint'($signed(b)) - sa;
    prod = 128'(sd < 0 ? -sd : sd) * 128'(t);
    off = longint'(prod / 128'(len));
    v = sa + (sd < 0 ? -off : off);
    return v[31:0];
  endfunction

  // Track one accepted vertex; on the last one, queue the resampled polyline.
  task automatic predict_vertex(input in_item_t it);
    logic [31:0] rx [VERTEX_DEPTH];
    logic [31:0] ry [VERTEX_DEPTH];
    logic [31:0] rz [VERTEX_DEPTH];
    int n, edges, nx, i, j;
    logic [1:0] st;
    longint unsigned total, goal, left, used, tg, t;
    logic [65:0] sq;
    longint d;
    bit done;
    out_item_t o;
    if (pv_count < VERTEX_DEPTH) begin
      pv_x[pv_count] = it.coord_x;
      pv_y[pv_count] = it.coord_y;
      pv_z[pv_count] = it.coord_z;
      pv_count++;
    end else begin
      pv_dropped = 1;
    end
    if (!it.last_vertex) return;
    n = pv_count;
    for (int k = 0; k < n; k++) begin
      rx[k] = pv_x[k];
      ry[k] = pv_y[k];
      rz[k] = pv_z[k];
    end
    st = pv_dropped ? ST_DROP : (n < 3 ? ST_SHORT : ST_OK);
    if (n >= 3) begin
      edges = closed_reg ? n : n - 1;
      total = 0;
      for (int k = 0; k < edges; k++) begin
        nx = (k + 1 == n) ? 0 : k + 1;
        sq = '0;
        d = longint'($signed(pv_x[nx])) - longint'($signed(pv_x[k]));
        sq += 66'(d < 0 ? -d : d) * 66'(d < 0 ? -d : d);
        d = longint'($signed(pv_y[nx])) - longint'($signed(pv_y[k]));
        sq += 66'(d < 0 ? -d : d) * 66'(d < 0 ? -d : d);
        d = longint'($signed(pv_z[nx])) - longint'($signed(pv_z[k]));
        sq += 66'(d < 0 ? -d : d) * 66'(d < 0 ? -d : d);
        edge_len[k] = floor_root(sq);
        total += edge_len[k];
      end
      goal = total / edges;
      if (goal > 0) begin
        i = 0;
        j = 1;
        left = edge_len[0];
        used = 0;
        tg = goal;
        done = 0;
        while (i < edges && !done) begin
          while (left > tg) begin
            // Never move a vertex at or beyond the edge count.
            if (j >= edges) begin
              done = 1;
              break;
            end
            nx = (i + 1 == n) ? 0 : i + 1;
            t = tg + used;
            rx[j] = lerp_axis(pv_x[i], pv_x[nx], t, edge_len[i]);
            ry[j] = lerp_axis(pv_y[i], pv_y[nx], t, edge_len[i]);
            rz[j] = lerp_axis(pv_z[i], pv_z[nx], t, edge_len[i]);
            left -= tg;
            used += tg;
            tg = goal;
            j++;
          end
          if (done) break;
          tg -= left;
          i++;
          left = (i < edges) ? edge_len[i] : 0;
          used = 0;
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      o.out_x = rx[k];
      o.out_y = ry[k];
      o.out_z = rz[k];
      o.vertex_index = 6'(k);
      o.last_out = (k + 1 == n);
      o.status = st;
      resampled_q.push_back(o);
    end
    pv_count = 0;
    pv_dropped = 0;
  endtask

  // Offer one vertex request after a random gap; hold it until accepted.
  task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input bit last);
    in_item_t it;
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    it.last_vertex = last;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_vertex(it);
    sent_count++;
  endtask

  function automatic logic [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom;                                   // full range
      1: return 32'($signed($urandom_range(0, 2**21)) - 2**20);
      2: return ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($urandom_range(0, 7)) << 16;       // coarse grid, repeats
    endcase
  endfunction

  task automatic send_polyline(input int len, input int mode);
    for (int k = 0; k < len; k++)
      send_vertex(rand_coord(mode), rand_coord(mode), rand_coord(mode), k == len - 1);
  endtask

  // Drop valid and wait until every owed vertex is out, plus a short tail.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (resampled_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Write closed_curve; only called while the block is idle.
  task automatic write_closed(input bit v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    closed_reg = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_short_polylines();
    // Fewer than three vertices pass through unchanged.
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0);
    send_vertex(32'h0, 32'h0001_0000, 32'h8000_0000, 1);
    wait_idle();
  endtask

  task automatic test_extreme_coords();
    // Opposite corners of the coordinate space give the longest edges.
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1);
    wait_idle();
  endtask

  task automatic test_zero_spacing();
    // All vertices coincide: spacing is zero and nothing moves.
    for (int k = 0; k < 4; k++) send_vertex(32'h1234_5678, 32'hDEAD_BEEF, 32'h0, k == 3);
    wait_idle();
  endtask

  task automatic test_open_closed();
    // Same shape open and closed, including the end vertex of an open curve.
    write_closed(0);
    send_vertex(32'h0, 32'h0, 32'h0, 0);
    send_vertex(32'h000A_0000, 32'h0, 32'h0, 0);
    send_vertex(32'h000A_0000, 32'h0001_0000, 32'h0, 0);
    send_vertex(32'h000A_0000, 32'h0014_0000, 32'h0, 1);
    wait_idle();
    write_closed(1);
    send_vertex(32'h0, 32'h0, 32'h0, 0);
    send_vertex(32'h000A_0000, 32'h0, 32'h0, 0);
    send_vertex(32'h000A_0000, 32'h0001_0000, 32'h0, 0);
    send_vertex(32'h000A_0000, 32'h0014_0000, 32'h0, 1);
    wait_idle();
  endtask

  task automatic test_overflow();
    // More vertices than the store holds: extras are dropped, status flags it; then an exactly full store.
    send_polyline(VERTEX_DEPTH + 3, 1);
    wait_idle();
    send_polyline(VERTEX_DEPTH, 0);
    wait_idle();
  endtask

  task automatic test_pressure();
    // Hold the receiver off while the next polyline keeps pushing.
    no_idle = 1;
    hold_req = 1;
    send_polyline(6, 1);
    send_polyline(8, 1);
    send_polyline(5, 0);
    no_idle = 0;
    wait_idle();
  endtask

  task automatic test_random();
    int len, pick;
    while (sent_count < 460) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) len = $urandom_range(1, 2);
      else if (pick < 8) len = $urandom_range(VERTEX_DEPTH - 4, VERTEX_DEPTH + 4);
      else len = $urandom_range(3, 10);
      no_idle = ($urandom_range(0, 9) == 0);
      send_polyline(len, $urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        write_closed(1'($urandom_range(0, 1)));
      end
    end
    no_idle = 0;
    wait_idle();
  endtask

  // Receiver: draw a stall per result, or serve one long hold-off on request.
  initial begin
    int n;
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 10);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each accepted vertex with the oldest owed one, field by field.
  always @(posedge clk) begin
    out_item_t exp_v;
    if (rst_n && out_valid && !out_stall) begin
      if (resampled_q.size() == 0) begin
        $display("%0t: unexpected vertex x=%h y=%h z=%h idx=%0d", $time,
                 out_data.out_x, out_data.out_y, out_data.out_z, out_data.vertex_index);
        fail_count++;
      end else begin
        exp_v = resampled_q.pop_front();
        if (out_data.out_x !== exp_v.out_x) begin
          $display("%0t: out_x expected %h got %h", $time, exp_v.out_x, out_data.out_x);
          fail_count++;
        end
        if (out_data.out_y !== exp_v.out_y) begin
          $display("%0t: out_y expected %h got %h", $time, exp_v.out_y, out_data.out_y);
          fail_count++;
        end
        if (out_data.out_z !== exp_v.out_z) begin
          $display("%0t: out_z expected %h got %h", $time, exp_v.out_z, out_data.out_z);
          fail_count++;
        end
        if (out_data.vertex_index !== exp_v.vertex_index) begin
          $display("%0t: vertex_index expected %0d got %0d", $time,
                   exp_v.vertex_index, out_data.vertex_index);
          fail_count++;
        end
        if (out_data.last_out !== exp_v.last_out) begin
          $display("%0t: last_out expected %b got %b", $time, exp_v.last_out,
                   out_data.last_out);
          fail_count++;
        end
        if (out_data.status !== exp_v.status) begin
          $display("%0t: status expected %0d got %0d", $time, exp_v.status, out_data.status);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no request moves on any channel.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL polyline_equal_length_resampler_unit");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_short_polylines();
    test_extreme_coords();
    test_zero_spacing();
    test_open_closed();
    test_overflow();
    test_pressure();
    test_random();
    write_closed(1);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && resampled_q.size() == 0) begin
      $display("PASS polyline_equal_length_resampler_unit");
    end else begin
      $display("FAIL polyline_equal_length_resampler_unit");
    end
    $finish;
  end

endmodule
`default_nettype wire
